### hw/rtl/hrlp_pkg.sv
// shared types, constants and tables of the http request line parser
`default_nettype none

package hrlp_pkg;

   // request size limit and the byte counter that saturates at it
   localparam int MAX_REQUEST_BYTES = 4096;
   localparam int COUNT_W           = $clog2(MAX_REQUEST_BYTES + 1);

   typedef logic [7:0]         byte_type;
   typedef logic [1:0]         kind_type;
   typedef logic [2:0]         method_type;
   typedef logic [1:0]         status_type;
   typedef logic [COUNT_W-1:0] count_type;

   // result kinds
   localparam kind_type KIND_PATH    = 2'd0;
   localparam kind_type KIND_QUERY   = 2'd1;
   localparam kind_type KIND_VERDICT = 2'd2;

   // verdicts
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_BAD     = 2'd1;
   localparam status_type STATUS_VERSION = 2'd2;

   // method codes
   localparam method_type METHOD_GET     = 3'd0;
   localparam method_type METHOD_POST    = 3'd1;
   localparam method_type METHOD_PUT     = 3'd2;
   localparam method_type METHOD_DELETE  = 3'd3;
   localparam method_type METHOD_CONNECT = 3'd4;
   localparam method_type METHOD_HEAD    = 3'd5;
   localparam method_type METHOD_OPTIONS = 3'd6;
   localparam method_type METHOD_TRACE   = 3'd7;
   localparam int         METHOD_COUNT   = 8;

   // character codes
   localparam byte_type CHAR_NUL   = 8'd0;
   localparam byte_type CHAR_LF    = 8'd10;
   localparam byte_type CHAR_CR    = 8'd13;
   localparam byte_type CHAR_SPACE = 8'd32;
   localparam byte_type CHAR_QMARK = 8'd63;

   // version text, first character in the top byte
   localparam logic [63:0] VERSION_TEXT = "http/1.1";

   // fold upper-case letters to lower case
   function automatic byte_type lower_byte(input byte_type c);
      byte_type r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // method name, left aligned, first character in the top byte
   function automatic logic [63:0] method_text(input method_type m);
      logic [63:0] r;
      case (m)
         METHOD_GET:     r = {"get", 40'h0};
         METHOD_POST:    r = {"post", 32'h0};
         METHOD_PUT:     r = {"put", 40'h0};
         METHOD_DELETE:  r = {"delete", 16'h0};
         METHOD_CONNECT: r = {"connect", 8'h0};
         METHOD_HEAD:    r = {"head", 32'h0};
         METHOD_OPTIONS: r = {"options", 8'h0};
         METHOD_TRACE:   r = {"trace", 24'h0};
         default:        r = '0;
      endcase
      return r;
   endfunction

   // length of each method name
   function automatic logic [3:0] method_len(input method_type m);
      logic [3:0] r;
      case (m)
         METHOD_GET:     r = 4'd3;
         METHOD_POST:    r = 4'd4;
         METHOD_PUT:     r = 4'd3;
         METHOD_DELETE:  r = 4'd6;
         METHOD_CONNECT: r = 4'd7;
         METHOD_HEAD:    r = 4'd4;
         METHOD_OPTIONS: r = 4'd7;
         METHOD_TRACE:   r = 4'd5;
         default:        r = 4'd0;
      endcase
      return r;
   endfunction

   // character k of a 64-bit left-aligned text
   function automatic byte_type text_char(input logic [63:0] text, input logic [2:0] k);
      logic [5:0] pos;
      pos = {3'd7 - k, 3'b000};
      return text[pos +: 8];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hrlp_if.sv
// valid/ready channel interfaces for request bytes and parser results
`default_nettype none

interface hrlp_req_if;
   logic              valid;
   logic              ready;
   hrlp_pkg::byte_type data_byte;
   logic              is_end;

   modport source (output valid, output data_byte, output is_end, input ready);
   modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface hrlp_rsp_if;
   logic                 valid;
   logic                 ready;
   hrlp_pkg::kind_type   kind;
   hrlp_pkg::byte_type   uri_byte;
   hrlp_pkg::method_type method_code;
   hrlp_pkg::status_type status;

   modport source (output valid, output kind, output uri_byte, output method_code,
                   output status, input ready);
   modport sink   (input valid, input kind, input uri_byte, input method_code,
                   input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/http_request_line_parser_unit.sv
// http request line parser: method match, uri streaming and version check
//
//   channel   | dir | carries
//   ----------+-----+----------------------------------------------------
//   req_chan  | in  | one request byte or an end marker per transfer
//   rsp_chan  | out | uri path/query byte or at most one verdict per request
//
// one byte per cycle sustained while rsp_chan takes results: a byte is held
// in the input register, is parsed against the line state and lands in the
// result register. both registers advance together whenever the result
// register is empty or being taken, so a stall on rsp_chan backs up into
// req_chan. synchronous reset returns the parser to the method phase with
// both registers empty.
`default_nettype none

module http_request_line_parser_unit (
   input  logic       clock,
   input  logic       reset,
   hrlp_req_if.sink   req_chan,
   hrlp_rsp_if.source rsp_chan
);
   import hrlp_pkg::*;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_URI_FIRST,
      PH_PATH,
      PH_QUERY,
      PH_VER_FIRST,
      PH_VER,
      PH_CR,
      PH_DONE
   } phase_type;

   // input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff,  in_byte_in;
   logic     in_end_ff,   in_end_in;

   // line state
   phase_type  phase_ff,    phase_in;
   logic [7:0] mask_ff,     mask_in;
   logic [3:0] m_idx_ff,    m_idx_in;
   method_type found_ff,    found_in;
   logic [3:0] v_idx_ff,    v_idx_in;
   logic       v_bad_ff,    v_bad_in;
   count_type  count_ff,    count_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   kind_type   kind_ff,      kind_in;
   byte_type   uri_ff,       uri_in;
   method_type method_ff,    method_in;
   status_type status_ff,    status_in;

   logic       advance;
   logic       process;
   byte_type   c;
   byte_type   lc;
   logic [7:0] mask_char;
   logic       method_hit;
   method_type method_hit_code;
   logic       ver_char_bad;

   // both registers move when the result slot is free or being emptied
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign process        = in_valid_ff && advance;

   // over-limit bytes behave as a zero byte
   assign c  = (count_ff >= count_type'(MAX_REQUEST_BYTES)) ? CHAR_NUL : in_byte_ff;
   assign lc = lower_byte(c);

   // per-method character compare and end-of-name match
   always_comb begin
      mask_char       = mask_ff;
      method_hit      = 1'b0;
      method_hit_code = METHOD_GET;
      for (int j = METHOD_COUNT - 1; j >= 0; j--) begin
         if (m_idx_ff >= method_len(method_type'(j)) ||
             text_char(method_text(method_type'(j)), m_idx_ff[2:0]) != lc) begin
            mask_char[j] = 1'b0;
         end
         if (mask_ff[j] && method_len(method_type'(j)) == m_idx_ff) begin
            method_hit      = 1'b1;
            method_hit_code = method_type'(j);
         end
      end
   end

   // version character compare
   assign ver_char_bad = (v_idx_ff >= 4'd8) ||
                         (text_char(VERSION_TEXT, v_idx_ff[2:0]) != lc);

   // next state of the line parser and the result register
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_end_in    = in_end_ff;
      phase_in     = phase_ff;
      mask_in      = mask_ff;
      m_idx_in     = m_idx_ff;
      found_in     = found_ff;
      v_idx_in     = v_idx_ff;
      v_bad_in     = v_bad_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      uri_in       = uri_ff;
      method_in    = method_ff;
      status_in    = status_ff;

      // input register load
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.data_byte;
         in_end_in   = req_chan.is_end;
      end

      if (advance) begin
         out_valid_in = 1'b0;
         kind_in      = KIND_VERDICT;
         uri_in       = '0;
         method_in    = found_ff;
         status_in    = STATUS_OK;
      end

      if (process) begin
         if (in_end_ff) begin
            // end marker: late verdict if a line was under way, then clear
            if (count_ff != '0 && phase_ff != PH_DONE) begin
               out_valid_in = 1'b1;
               status_in    = STATUS_BAD;
            end
            phase_in = PH_METHOD;
            mask_in  = '1;
            m_idx_in = '0;
            found_in = METHOD_GET;
            v_idx_in = '0;
            v_bad_in = 1'b0;
            count_in = '0;
         end else if (phase_ff != PH_DONE) begin
            if (count_ff < count_type'(MAX_REQUEST_BYTES)) begin
               count_in = count_ff + count_type'(1);
            end
            case (phase_ff)
               PH_METHOD: begin
                  if (c == CHAR_NUL) begin
                     out_valid_in = 1'b1;
                     status_in    = STATUS_BAD;
                     phase_in     = PH_DONE;
                  end else if (c == CHAR_SPACE) begin
                     if (method_hit) begin
                        found_in = method_hit_code;
                        phase_in = PH_URI_FIRST;
                     end else begin
                        out_valid_in = 1'b1;
                        status_in    = STATUS_BAD;
                        phase_in     = PH_DONE;
                     end
                  end else begin
                     mask_in = mask_char;
                     if (m_idx_ff < 4'd8) begin
                        m_idx_in = m_idx_ff + 4'd1;
                     end
                  end
               end
               PH_URI_FIRST, PH_PATH, PH_QUERY: begin
                  if (c == CHAR_NUL ||
                      (phase_ff == PH_URI_FIRST && c == CHAR_SPACE)) begin
                     out_valid_in = 1'b1;
                     status_in    = STATUS_BAD;
                     phase_in     = PH_DONE;
                  end else if (c == CHAR_SPACE) begin
                     phase_in = PH_VER_FIRST;
                  end else if (phase_ff != PH_QUERY && c == CHAR_QMARK) begin
                     phase_in = PH_QUERY;
                  end else begin
                     out_valid_in = 1'b1;
                     kind_in      = (phase_ff == PH_QUERY) ? KIND_QUERY : KIND_PATH;
                     uri_in       = c;
                     phase_in     = (phase_ff == PH_QUERY) ? PH_QUERY : PH_PATH;
                  end
               end
               PH_VER_FIRST, PH_VER: begin
                  if (c == CHAR_NUL ||
                      (phase_ff == PH_VER_FIRST && c == CHAR_SPACE)) begin
                     out_valid_in = 1'b1;
                     status_in    = STATUS_BAD;
                     phase_in     = PH_DONE;
                  end else if (c == CHAR_CR) begin
                     phase_in = PH_CR;
                  end else if (c == CHAR_LF) begin
                     out_valid_in = 1'b1;
                     status_in    = (v_bad_ff || v_idx_ff != 4'd8) ? STATUS_VERSION
                                                                   : STATUS_OK;
                     phase_in     = PH_DONE;
                  end else begin
                     phase_in = PH_VER;
                     if (ver_char_bad) begin
                        v_bad_in = 1'b1;
                     end
                     if (v_idx_ff < 4'd9) begin
                        v_idx_in = v_idx_ff + 4'd1;
                     end
                  end
               end
               PH_CR: begin
                  out_valid_in = 1'b1;
                  phase_in     = PH_DONE;
                  if (c == CHAR_LF) begin
                     status_in = (v_bad_ff || v_idx_ff != 4'd8) ? STATUS_VERSION
                                                                : STATUS_OK;
                  end else begin
                     status_in = STATUS_BAD;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_METHOD;
         mask_ff      <= '1;
         m_idx_ff     <= '0;
         found_ff     <= METHOD_GET;
         v_idx_ff     <= '0;
         v_bad_ff     <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         mask_ff      <= mask_in;
         m_idx_ff     <= m_idx_in;
         found_ff     <= found_in;
         v_idx_ff     <= v_idx_in;
         v_bad_ff     <= v_bad_in;
         count_ff     <= count_in;
      end
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      kind_ff    <= kind_in;
      uri_ff     <= uri_in;
      method_ff  <= method_in;
      status_ff  <= status_in;
   end

   // result channel
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.uri_byte    = uri_ff;
   assign rsp_chan.method_code = method_ff;
   assign rsp_chan.status      = status_ff;

endmodule

`default_nettype wire

### tb/http_request_line_parser_unit_tb.sv
// testbench of the http request line parser: directed and random requests checked in order
`timescale 1ns / 100ps

module http_request_line_parser_unit_tb;
   import hrlp_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int MAX_PRINTED = 40;

   // parse phases of the request line
   typedef enum logic [2:0] {
      LINE_METHOD,
      LINE_URI_FIRST,
      LINE_PATH,
      LINE_QUERY,
      LINE_VER_FIRST,
      LINE_VER,
      LINE_CR,
      LINE_DONE
   } line_phase_type;

   typedef struct packed {
      kind_type   kind;
      byte_type   uri_byte;
      method_type method_code;
      status_type status;
   } line_result_type;

   logic clock;
   logic reset;

   hrlp_req_if req_bus ();
   hrlp_rsp_if rsp_bus ();

   http_request_line_parser_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // method names in code order, and the only accepted version
   string method_word [METHOD_COUNT] = '{"get", "post", "put", "delete",
                                         "connect", "head", "options", "trace"};
   string version_word = "http/1.1";

   // parser state as predicted
   line_phase_type line_phase;
   logic [7:0]     name_mask;
   logic [3:0]     name_idx;
   method_type     found_method;
   logic [3:0]     ver_idx;
   logic           ver_mismatch;
   count_type      req_count;

   line_result_type expected_rsp [$];
   int          error_count = 0;
   int          byte_total  = 0;
   int          cycle_count = 0;
   int          hold_left   = 0;
   bit          idle_on     = 1'b1;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic void reset_line_state();
      line_phase   = LINE_METHOD;
      name_mask    = 8'hFF;
      name_idx     = '0;
      found_method = METHOD_GET;
      ver_idx      = '0;
      ver_mismatch = 1'b0;
      req_count    = '0;
   endfunction

   function automatic byte_type fold_case(input byte_type c);
      if (c >= 8'd65 && c <= 8'd90) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // one verdict closes the line
   function automatic line_result_type close_line(input status_type st);
      line_result_type r;
      line_phase    = LINE_DONE;
      r.kind        = KIND_VERDICT;
      r.uri_byte    = '0;
      r.method_code = found_method;
      r.status      = st;
      return r;
   endfunction

   // advance the predicted parser by one transfer, returns 1 when a result is due
   function automatic bit parse_byte(input byte_type raw, input logic end_flag,
                                     output line_result_type r);
      byte_type c;
      byte_type lc;
      bit       hit;
      bit       matched;
      int       j;
      r   = '0;
      hit = 1'b0;
      c   = raw;
      if (end_flag) begin
         if (req_count != 0 && line_phase != LINE_DONE) begin
            r   = close_line(STATUS_BAD);
            hit = 1'b1;
         end
         reset_line_state();
         return hit;
      end
      if (line_phase == LINE_DONE) begin
         return 1'b0;
      end
      // bytes past the size limit behave as a zero byte
      if (req_count >= MAX_REQUEST_BYTES) begin
         c = CHAR_NUL;
      end else begin
         req_count++;
      end
      lc = fold_case(c);
      case (line_phase)
         LINE_METHOD: begin
            if (c == CHAR_NUL) begin
               r   = close_line(STATUS_BAD);
               hit = 1'b1;
            end else if (c == CHAR_SPACE) begin
               matched = 1'b0;
               for (j = 0; j < METHOD_COUNT; j++) begin
                  if (!matched && name_mask[j] && method_word[j].len() == name_idx) begin
                     found_method = method_type'(j);
                     matched      = 1'b1;
                  end
               end
               if (matched) begin
                  line_phase = LINE_URI_FIRST;
               end else begin
                  r   = close_line(STATUS_BAD);
                  hit = 1'b1;
               end
            end else begin
               for (j = 0; j < METHOD_COUNT; j++) begin
                  if (name_idx >= method_word[j].len() || method_word[j][name_idx] != lc) begin
                     name_mask[j] = 1'b0;
                  end
               end
               if (name_idx < 8) begin
                  name_idx++;
               end
            end
         end
         LINE_URI_FIRST, LINE_PATH, LINE_QUERY: begin
            if (c == CHAR_NUL || (line_phase == LINE_URI_FIRST && c == CHAR_SPACE)) begin
               r   = close_line(STATUS_BAD);
               hit = 1'b1;
            end else if (c == CHAR_SPACE) begin
               line_phase = LINE_VER_FIRST;
            end else if (line_phase != LINE_QUERY && c == CHAR_QMARK) begin
               line_phase = LINE_QUERY;
            end else begin
               r.kind        = (line_phase == LINE_QUERY) ? KIND_QUERY : KIND_PATH;
               r.uri_byte    = c;
               r.method_code = found_method;
               r.status      = STATUS_OK;
               hit           = 1'b1;
               line_phase    = (line_phase == LINE_QUERY) ? LINE_QUERY : LINE_PATH;
            end
         end
         LINE_VER_FIRST, LINE_VER: begin
            if (c == CHAR_NUL || (line_phase == LINE_VER_FIRST && c == CHAR_SPACE)) begin
               r   = close_line(STATUS_BAD);
               hit = 1'b1;
            end else if (c == CHAR_CR) begin
               line_phase = LINE_CR;
            end else if (c == CHAR_LF) begin
               r   = close_line((ver_mismatch || ver_idx != 8) ? STATUS_VERSION : STATUS_OK);
               hit = 1'b1;
            end else begin
               line_phase = LINE_VER;
               if (ver_idx >= 8 || version_word[ver_idx] != lc) begin
                  ver_mismatch = 1'b1;
               end
               if (ver_idx < 9) begin
                  ver_idx++;
               end
            end
         end
         LINE_CR: begin
            if (c == CHAR_LF) begin
               r = close_line((ver_mismatch || ver_idx != 8) ? STATUS_VERSION : STATUS_OK);
            end else begin
               r = close_line(STATUS_BAD);
            end
            hit = 1'b1;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      return hit;
   endfunction

   // result checker
   always @(posedge clock) begin : check_results
      line_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, kind %0d byte %0d",
                                      rsp_bus.kind, rsp_bus.uri_byte));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_bus.kind !== want.kind) begin
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_bus.kind, want.kind));
            end
            if (rsp_bus.uri_byte !== want.uri_byte) begin
               report_mismatch($sformatf("uri_byte %0d, expected %0d",
                                         rsp_bus.uri_byte, want.uri_byte));
            end
            if (rsp_bus.method_code !== want.method_code) begin
               report_mismatch($sformatf("method_code %0d, expected %0d",
                                         rsp_bus.method_code, want.method_code));
            end
            if (rsp_bus.status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_bus.status, want.status));
            end
         end
      end
   end

   // result side: random stalls, plus a long hold-off when asked for
   initial begin : receiver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 18);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one transfer on the request side, called at a falling edge
   task automatic send_byte(input byte_type b, input logic end_flag);
      line_result_type r;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.is_end    <= end_flag;
      do @(posedge clock); while (!req_bus.ready);
      if (parse_byte(b, end_flag, r)) begin
         expected_rsp.push_back(r);
      end
      byte_total++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i], 1'b0);
      end
   endtask

   task automatic send_line(input string head, input bit crlf);
      send_text(head);
      if (crlf) begin
         send_byte(CHAR_CR, 1'b0);
      end
      send_byte(CHAR_LF, 1'b0);
   endtask

   task automatic send_end();
      send_byte(byte_type'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic byte_type random_case(input byte_type c);
      if (c >= 8'd97 && c <= 8'd122 && $urandom_range(0, 1) == 1) begin
         return c - 8'd32;
      end
      return c;
   endfunction

   function automatic byte_type uri_safe_byte();
      byte_type b;
      do b = byte_type'($urandom_range(1, 255));
      while (b == CHAR_SPACE || b == CHAR_QMARK);
      return b;
   endfunction

   // bytes weighted towards the ones the parser reacts to
   function automatic byte_type noise_byte();
      case ($urandom_range(0, 7))
         0:       return CHAR_NUL;
         1:       return CHAR_LF;
         2:       return CHAR_CR;
         3:       return CHAR_SPACE;
         4:       return CHAR_QMARK;
         5:       return random_case(8'd116);
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed lines with random content, some noise
   task automatic send_random_request();
      string name;
      int    i;
      int    len;
      int    qpos;
      int    cut;
      int    pick;
      pick = $urandom_range(0, 9);
      if (pick >= 8) begin
         len = $urandom_range(1, 16);
         for (i = 0; i < len; i++) begin
            send_byte(noise_byte(), 1'b0);
         end
         send_end();
         return;
      end
      // method, sometimes cut short or with a stray letter
      name = method_word[$urandom_range(0, METHOD_COUNT - 1)];
      cut  = ($urandom_range(0, 11) == 0) ? 1 : 0;
      for (i = 0; i < name.len() - cut; i++) begin
         send_byte(random_case(name[i]), 1'b0);
      end
      if ($urandom_range(0, 11) == 0) begin
         send_byte(random_case(8'd120), 1'b0);
      end
      send_byte(CHAR_SPACE, 1'b0);
      // uri with an optional query part
      len  = $urandom_range(1, 12);
      qpos = $urandom_range(0, len);
      for (i = 0; i < len; i++) begin
         if (i == qpos || (i > qpos && $urandom_range(0, 7) == 0)) begin
            send_byte(CHAR_QMARK, 1'b0);
         end else begin
            send_byte(uri_safe_byte(), 1'b0);
         end
      end
      send_byte(CHAR_SPACE, 1'b0);
      // version
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         for (i = 0; i < version_word.len(); i++) begin
            send_byte(random_case(version_word[i]), 1'b0);
         end
      end else if (pick == 7) begin
         send_text("HTTP/1.0");
      end else if (pick == 8) begin
         len = $urandom_range(1, 10);
         for (i = 0; i < len; i++) begin
            send_byte(($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                 : byte_type'($urandom_range(33, 126)), 1'b0);
         end
      end
      // line end: cr lf, lone lf, or a bare cr
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
         send_byte(CHAR_CR, 1'b0);
         send_byte(CHAR_LF, 1'b0);
      end else if (pick <= 8) begin
         send_byte(CHAR_LF, 1'b0);
      end else begin
         send_byte(CHAR_CR, 1'b0);
         send_byte(byte_type'($urandom_range(0, 255)), 1'b0);
      end
      // header bytes after the line are ignored
      if ($urandom_range(0, 2) == 0) begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++) begin
            send_byte(byte_type'($urandom_range(0, 255)), 1'b0);
         end
      end
      send_end();
   endtask

   // every method, mixed case, both line ends, plus unknown methods
   task automatic test_methods();
      send_line("get /?x http/1.1", 1'b0);
      send_end();
      send_line("POST /p?q?r HTTP/1.1", 1'b1);
      send_end();
      send_line("PuT / hTTp/1.1", 1'b0);
      send_end();
      send_line("DELETE /d HTTP/1.1", 1'b1);
      send_end();
      send_line("connect h:1 HTTP/1.1", 1'b0);
      send_end();
      send_line("HEAD / HTTP/1.1", 1'b0);
      send_end();
      send_line("OPTIONS * HTTP/1.1", 1'b1);
      send_end();
      send_line("TRACE ?k HTTP/1.1", 1'b0);
      send_end();
      send_line("GETS / HTTP/1.1", 1'b0);
      send_end();
      send_line("GE / HTTP/1.1", 1'b0);
      send_end();
      send_line(" / HTTP/1.1", 1'b0);
      send_end();
   endtask

   // separators, line ends, versions, early ends and ignored bytes
   task automatic test_malformed();
      // doubled space after the method and after the uri
      send_line("GET  /a HTTP/1.1", 1'b0);
      send_end();
      send_line("GET /a  HTTP/1.1", 1'b0);
      send_end();
      // end right after either separator, and inside the method
      send_text("GET ");
      send_end();
      send_text("GET /a ");
      send_end();
      send_text("GE");
      send_end();
      // bare cr
      send_text("GET /a HTTP/1.1");
      send_byte(CHAR_CR, 1'b0);
      send_byte(8'd120, 1'b0);
      send_end();
      // zero byte in the uri and as the first byte
      send_text("GET /a");
      send_byte(CHAR_NUL, 1'b0);
      send_end();
      send_byte(CHAR_NUL, 1'b0);
      send_end();
      // empty and odd versions
      send_line("GET /a ", 1'b0);
      send_end();
      send_line("GET /a ", 1'b1);
      send_end();
      send_line("GET /a HTTP/1.0", 1'b1);
      send_end();
      send_line("GET /a http/1.1x", 1'b0);
      send_end();
      send_line("GET /a HT TP/1.1", 1'b0);
      send_end();
      // end item with no bytes gives nothing
      send_end();
      // after the verdict bytes are ignored and the end item is silent
      send_line("XYZ a b", 1'b0);
      send_end();
   endtask

   // every uri byte value and the top byte as a method character
   task automatic test_byte_range();
      int v;
      send_text("put /");
      for (v = 1; v < 256; v++) begin
         if (v != CHAR_SPACE && v != CHAR_QMARK) begin
            send_byte(byte_type'(v), 1'b0);
         end
      end
      send_line(" HTTP/1.1", 1'b1);
      send_end();
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
      send_end();
   endtask

   // requests that reach the size limit
   task automatic test_over_length();
      int i;
      // path runs past the limit
      send_text("get /");
      for (i = 0; i < MAX_REQUEST_BYTES - 1; i++) begin
         send_byte(uri_safe_byte(), 1'b0);
      end
      send_end();
      // line end is the last byte within the limit
      send_text("GET /");
      for (i = 0; i < MAX_REQUEST_BYTES - 16; i++) begin
         send_byte(uri_safe_byte(), 1'b0);
      end
      send_line(" HTTP/1.1", 1'b1);
      send_end();
      // line end falls one byte past the limit
      send_text("GET /");
      for (i = 0; i < MAX_REQUEST_BYTES - 15; i++) begin
         send_byte(uri_safe_byte(), 1'b0);
      end
      send_line(" HTTP/1.1", 1'b1);
      send_end();
   endtask

   // long result stall while requests keep coming
   task automatic test_backpressure();
      int i;
      hold_left = 300;
      send_text("OPTIONS /");
      for (i = 0; i < 60; i++) begin
         send_byte(uri_safe_byte(), 1'b0);
      end
      send_line(" HTTP/1.1", 1'b1);
      send_end();
      send_random_request();
      send_random_request();
   endtask

   task automatic test_random(input int target);
      int start;
      start = byte_total;
      while (byte_total - start < target) begin
         send_random_request();
      end
   endtask

   // stimulus sequence
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.is_end    = 1'b0;
      reset             = 1'b1;
      reset_line_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_methods();
      test_malformed();
      test_byte_range();
      test_over_length();
      test_backpressure();
      test_random(550);
      // steady stream to finish
      idle_on = 1'b0;
      test_random(150);

      // drain outstanding results
      req_bus.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### http_request_line_parser_unit.f
hw/rtl/hrlp_pkg.sv
hw/rtl/hrlp_if.sv
hw/rtl/http_request_line_parser_unit.sv
tb/http_request_line_parser_unit_tb.sv
